// File: sv/hbp_pkg.sv
// Shared types and constants for the Huffman bit packer.
package hbp_pkg;

   localparam int SYM_W = 8;
   localparam int CODE_W = 32;
   localparam int LEN_W = 6;
   localparam int BYTE_W = 8;
   localparam int PEND_W = 7;
   localparam int PCNT_W = 3;
   localparam int MAX_BYTES = 4;
   localparam int TABLE_DEPTH = 1 << SYM_W;
   localparam int MAX_CODE_LEN = 32;
   localparam int LEN_CAP_INT = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
   localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(LEN_CAP_INT);

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [SYM_W-1:0] PAD_RESET = 8'd32;

   typedef enum logic [1:0] {
      CMD_LOAD   = 2'd0,
      CMD_ENCODE = 2'd1,
      CMD_FLUSH  = 2'd2
   } cmd_type;

   typedef struct packed {
      logic [CODE_W-1:0] code;
      logic [LEN_W-1:0]  len;
   } entry_type;

   typedef struct packed {
      logic             en;
      logic [SYM_W-1:0] addr;
      entry_type        entry;
   } table_wr_type;

   typedef struct packed {
      logic             en;
      logic [SYM_W-1:0] addr;
   } table_rd_type;

endpackage

// File: sv/hbp_table.sv
// Code table: synchronous memory of code words with per-entry length valid bits.
module hbp_table (
   input  logic                 clock,
   input  logic                 reset,
   input  hbp_pkg::table_wr_type wr,
   input  hbp_pkg::table_rd_type rd,
   output hbp_pkg::entry_type    rd_entry
);
   import hbp_pkg::*;

   entry_type               mem_ff [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0]  valid_ff;
   entry_type               rd_data_ff;
   logic                    rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.entry;
      end
      if (rd.en) begin
         rd_data_ff  <= mem_ff[rd.addr];
         rd_valid_ff <= valid_ff[rd.addr];
      end
   end

   // an entry never loaded reads back with zero length
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.en) begin
         valid_ff[wr.addr] <= 1'b1;
      end
   end

   assign rd_entry.code = rd_data_ff.code;
   assign rd_entry.len  = rd_valid_ff ? rd_data_ff.len : '0;

endmodule

// File: sv/huffman_bit_packer.sv
// Huffman bit packer top level: code table, packing stage and output word buffer.
// Takes one item per cycle while req_stall is low. A load writes the code table at
// acceptance; an encode or flush reads the table (registered, pad symbol's entry for a
// flush) and then enters the packing stage, which merges the code with up to 7 pending
// bits and hands 0 to 4 finished bytes to the output buffer. The buffer sends one word
// per cycle unless the receiver stalls, so an item of k bytes holds the next item and
// the input until its last byte is accepted; items of at most one byte stream at full
// rate. Table lengths reset to zero at once through per-entry valid bits; no clearing pass.
module huffman_bit_packer (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_command,
   input  logic [hbp_pkg::SYM_W-1:0]         req_symbol,
   input  logic [hbp_pkg::CODE_W-1:0]        req_code_bits,
   input  logic [hbp_pkg::LEN_W-1:0]         req_code_length,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [hbp_pkg::BYTE_W-1:0]        rsp_out_byte,
   output logic                              rsp_last_of_run,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [hbp_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [hbp_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [hbp_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready
);
   import hbp_pkg::*;

   logic               req_accept;
   logic               rsp_accept;
   logic               is_work;
   table_wr_type       tbl_wr;
   table_rd_type       tbl_rd;
   entry_type          tbl_entry;

   logic [SYM_W-1:0]   pad_ff;
   logic               s1_valid_ff, s1_valid_in;
   logic               s1_flush_ff;
   logic               s1_adv;

   logic [PEND_W-1:0]  pend_bits_ff, pend_bits_in;
   logic [PCNT_W-1:0]  pend_cnt_ff, pend_cnt_in;

   logic [BYTE_W-1:0]  obuf_ff [MAX_BYTES];
   logic [BYTE_W-1:0]  obuf_in [MAX_BYTES];
   logic [PCNT_W-1:0]  obuf_cnt_ff, obuf_cnt_in;
   logic               obuf_free;
   logic               obuf_load;

   // packing stage results
   logic [CODE_W-1:0]  code_mask;
   logic [CODE_W-1:0]  code_al;
   logic [38:0]        acc;
   logic [5:0]         total;
   logic [63:0]        aligned;
   logic [PEND_W-1:0]  pad_head;
   logic [2:0]         pad_pos;
   logic [PEND_W-1:0]  pad_stream;
   logic [BYTE_W-1:0]  flush_byte;
   logic [PCNT_W-1:0]  s1_n;
   logic [BYTE_W-1:0]  s1_bytes [MAX_BYTES];
   logic [PEND_W-1:0]  s1_pend_bits;
   logic [PCNT_W-1:0]  s1_pend_cnt;
   logic [BYTE_W-1:0]  cnt_mask;

   // configuration port
   assign pready = 1'b1;
   assign prdata = !paddr[2] ? CSR_DATA_W'(pad_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         pad_ff <= PAD_RESET;
      end else if (psel && penable && pwrite && pready && !paddr[2]) begin
         pad_ff <= pwdata[SYM_W-1:0];
      end
   end

   // input side
   assign req_accept = req_valid && !req_stall;
   assign is_work    = (req_command == CMD_ENCODE) || (req_command == CMD_FLUSH);
   assign req_stall  = s1_valid_ff && !s1_adv;

   always_comb begin
      tbl_wr.en          = req_accept && (req_command == CMD_LOAD);
      tbl_wr.addr        = req_symbol;
      tbl_wr.entry.code  = req_code_bits;
      tbl_wr.entry.len   = (req_code_length > LEN_CAP) ? LEN_CAP : req_code_length;
      tbl_rd.en          = req_accept;
      tbl_rd.addr        = (req_command == CMD_FLUSH) ? pad_ff : req_symbol;
   end

   hbp_table u_table (
      .clock    (clock),
      .reset    (reset),
      .wr       (tbl_wr),
      .rd       (tbl_rd),
      .rd_entry (tbl_entry)
   );

   // packing stage
   always_comb begin
      code_mask = (tbl_entry.len >= 6'd32) ? '1 : ((32'd1 << tbl_entry.len) - 32'd1);
      code_al   = (tbl_entry.code & code_mask) << (6'd32 - tbl_entry.len);
      acc       = ({32'b0, pend_bits_ff} << tbl_entry.len)
                  | {7'b0, tbl_entry.code & code_mask};
      total     = {3'b0, pend_cnt_ff} + tbl_entry.len;
      aligned   = {25'b0, acc} << (7'd64 - {1'b0, total});

      // repeat the pad code from its first bit
      pad_head   = code_al[CODE_W-1 -: PEND_W];
      pad_pos    = '0;
      pad_stream = '0;
      if (tbl_entry.len >= 6'd7) begin
         pad_stream = pad_head;
      end else begin
         for (int p = 1; p < 7; p++) begin
            if (tbl_entry.len == LEN_W'(p)) begin
               pad_pos = '0;
               for (int j = 0; j < 7; j++) begin
                  pad_stream[6-j] = pad_head[3'd6 - pad_pos];
                  pad_pos = (pad_pos == 3'(p - 1)) ? 3'd0 : pad_pos + 3'd1;
               end
            end
         end
      end
      flush_byte = BYTE_W'({1'b0, pend_bits_ff} << (4'd8 - {1'b0, pend_cnt_ff}))
                   | BYTE_W'({pad_stream, 1'b0} >> pend_cnt_ff);

      cnt_mask = (8'd1 << total[2:0]) - 8'd1;
      for (int k = 0; k < MAX_BYTES; k++) begin
         s1_bytes[k] = aligned[63-8*k -: 8];
      end

      if (s1_flush_ff) begin
         s1_n         = (pend_cnt_ff != '0) ? 3'd1 : 3'd0;
         s1_bytes[0]  = flush_byte;
         s1_pend_bits = '0;
         s1_pend_cnt  = '0;
      end else begin
         s1_n         = total[5:3];
         s1_pend_bits = acc[PEND_W-1:0] & cnt_mask[PEND_W-1:0];
         s1_pend_cnt  = total[2:0];
      end
   end

   assign rsp_accept = rsp_valid && !rsp_stall;
   assign obuf_free  = (obuf_cnt_ff == '0) || ((obuf_cnt_ff == 3'd1) && rsp_accept);
   assign s1_adv     = s1_valid_ff && ((s1_n == '0) || obuf_free);
   assign obuf_load  = s1_adv && (s1_n != '0);

   always_comb begin
      s1_valid_in  = (s1_valid_ff && !s1_adv) || (req_accept && is_work);
      pend_bits_in = s1_adv ? s1_pend_bits : pend_bits_ff;
      pend_cnt_in  = s1_adv ? s1_pend_cnt : pend_cnt_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         pend_bits_ff <= '0;
         pend_cnt_ff  <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         pend_bits_ff <= pend_bits_in;
         pend_cnt_ff  <= pend_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_flush_ff <= (req_command == CMD_FLUSH);
      end
   end

   // output word buffer: load a whole item's bytes, shift one out per accepted word
   always_comb begin
      obuf_cnt_in = obuf_cnt_ff;
      for (int k = 0; k < MAX_BYTES; k++) begin
         obuf_in[k] = obuf_ff[k];
      end
      if (obuf_load) begin
         obuf_cnt_in = s1_n;
         for (int k = 0; k < MAX_BYTES; k++) begin
            obuf_in[k] = s1_bytes[k];
         end
      end else if (rsp_accept) begin
         obuf_cnt_in = obuf_cnt_ff - 3'd1;
         for (int k = 0; k < MAX_BYTES - 1; k++) begin
            obuf_in[k] = obuf_ff[k+1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         obuf_cnt_ff <= '0;
      end else begin
         obuf_cnt_ff <= obuf_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < MAX_BYTES; k++) begin
         obuf_ff[k] <= obuf_in[k];
      end
   end

   assign rsp_valid       = (obuf_cnt_ff != '0);
   assign rsp_out_byte    = obuf_ff[0];
   assign rsp_last_of_run = (obuf_cnt_ff == 3'd1);

   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff)
      else $error("input stalled with empty packing stage");

   a_held_item_keeps_data: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_adv) |=> (s1_valid_ff && $stable(tbl_entry.len)))
      else $error("table data changed under a held item");

   a_flush_clears_pending: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && s1_flush_ff) |=> (pend_cnt_ff == '0))
      else $error("pending bits left after flush");

   a_last_word_drains: assert property (@(posedge clock) disable iff (reset)
      (rsp_accept && rsp_last_of_run && !obuf_load) |=> !rsp_valid)
      else $error("output buffer not empty after last word");

endmodule

// File: tb/sv/huffman_bit_packer_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the Huffman bit packer: code table loads, encode streams, flushes.
module huffman_bit_packer_tb;
   import hbp_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_PAD_SYMBOL = '0;
   localparam int LEN_LIMIT = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
   localparam int DRAIN_CYCLES = 8;
   localparam int CYCLE_LIMIT = 300000;

   typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY} stall_mode_type;

   typedef struct {
      logic [1:0]        command;
      logic [SYM_W-1:0]  symbol;
      logic [CODE_W-1:0] code_bits;
      logic [LEN_W-1:0]  code_length;
   } packer_req_type;

   typedef struct {
      logic [BYTE_W-1:0] data;
      logic              last;
   } packed_byte_type;

   class byte_stream_scoreboard;
      logic [CODE_W-1:0] code_tbl [TABLE_DEPTH];
      logic [LEN_W-1:0]  len_tbl [TABLE_DEPTH];
      logic [PEND_W-1:0] pend_bits;
      int                pend_cnt;
      logic [SYM_W-1:0]  pad_sym;
      packed_byte_type   expected_bytes [$];
      int                errors;

      function new();
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            code_tbl[i] = '0;
            len_tbl[i] = '0;
         end
         pend_bits = '0;
         pend_cnt = 0;
         pad_sym = PAD_RESET;
         errors = 0;
      endfunction

      function void set_pad(logic [SYM_W-1:0] s);
         pad_sym = s;
      endfunction

      function void push_byte(logic [BYTE_W-1:0] d, logic l);
         packed_byte_type w;
         w.data = d;
         w.last = l;
         expected_bytes.push_back(w);
      endfunction

      task report_mismatch(string msg);
         $display("[%0t] MISMATCH %s", $realtime, msg);
         errors++;
      endtask

      // Work out the words one accepted item produces and advance the packer state.
      function void pack_item(packer_req_type it);
         logic [63:0]       code;
         logic [63:0]       acc;
         logic [BYTE_W-1:0] pad_byte;
         int                len;
         int                total;
         int                plen;
         int                pos;
         case (it.command)
            CMD_LOAD: begin
               code_tbl[it.symbol] = it.code_bits;
               len_tbl[it.symbol] = (it.code_length > LEN_LIMIT) ? LEN_W'(LEN_LIMIT)
                                                                 : it.code_length;
            end
            CMD_ENCODE: begin
               len = len_tbl[it.symbol];
               code = {32'b0, code_tbl[it.symbol]};
               if (len < 32) code &= (64'd1 << len) - 64'd1;
               acc = ({57'b0, pend_bits} << len) | code;
               total = pend_cnt + len;
               while (total >= 8) begin
                  push_byte(BYTE_W'(acc >> (total - 8)), total < 16);
                  total -= 8;
               end
               pend_cnt = total;
               pend_bits = PEND_W'(acc & ((64'd1 << total) - 64'd1));
            end
            CMD_FLUSH: begin
               if (pend_cnt > 0) begin
                  pad_byte = BYTE_W'(pend_bits);
                  plen = len_tbl[pad_sym];
                  pos = 0;
                  // cycle the pad code from its first bit; an empty code pads with zeros
                  for (int n = pend_cnt; n < 8; n++) begin
                     if (plen > 0) begin
                        if (pos >= plen) pos = 0;
                        pad_byte = {pad_byte[6:0], code_tbl[pad_sym][plen-1-pos]};
                        pos++;
                     end else begin
                        pad_byte = {pad_byte[6:0], 1'b0};
                     end
                  end
                  push_byte(pad_byte, 1'b1);
                  pend_bits = '0;
                  pend_cnt = 0;
               end
            end
            default: ;
         endcase
      endfunction

      task check_word(logic [BYTE_W-1:0] d, logic l);
         packed_byte_type w;
         if (expected_bytes.size() == 0) begin
            report_mismatch($sformatf("unexpected word %02h last %0b", d, l));
            return;
         end
         w = expected_bytes.pop_front();
         if (d !== w.data)
            report_mismatch($sformatf("out_byte %02h, want %02h", d, w.data));
         if (l !== w.last)
            report_mismatch($sformatf("last_of_run %0b, want %0b", l, w.last));
      endtask
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [1:0]            req_command;
   logic [SYM_W-1:0]      req_symbol;
   logic [CODE_W-1:0]     req_code_bits;
   logic [LEN_W-1:0]      req_code_length;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [BYTE_W-1:0]     rsp_out_byte;
   logic                  rsp_last_of_run;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   byte_stream_scoreboard sb = new();
   packer_req_type        stim_q [$];
   int                    loaded_syms [$];
   int                    cycle_count = 0;
   logic                  sender_gaps = 1'b1;
   stall_mode_type        stall_mode = STALL_LIGHT;

   huffman_bit_packer dut (
      .clock, .reset,
      .req_valid, .req_stall, .req_command, .req_symbol, .req_code_bits, .req_code_length,
      .rsp_valid, .rsp_stall, .rsp_out_byte, .rsp_last_of_run,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("huffman_bit_packer verification failed");
         $finish;
      end
   end

   // Receiver: check accepted words, stall in runs of random length.
   initial begin
      int   run_left;
      logic stall_now;
      run_left = 0;
      stall_now = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall)
            sb.check_word(rsp_out_byte, rsp_last_of_run);
         if (run_left == 0) begin
            run_left = $urandom_range(1, 6);
            case (stall_mode)
               STALL_NONE:  stall_now = 1'b0;
               STALL_LIGHT: stall_now = ($urandom_range(0, 3) == 0);
               default:     stall_now = ($urandom_range(0, 1) == 0);
            endcase
         end
         run_left--;
         rsp_stall <= stall_now;
      end
   end

   function automatic packer_req_type mk_req(logic [1:0] c, logic [SYM_W-1:0] s,
                                             logic [CODE_W-1:0] b, logic [LEN_W-1:0] l);
      packer_req_type it;
      it.command = c;
      it.symbol = s;
      it.code_bits = b;
      it.code_length = l;
      return it;
   endfunction

   function automatic logic [LEN_W-1:0] rand_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 5) return '0;
      if (r < 70) return LEN_W'($urandom_range(1, 12));
      if (r < 90) return LEN_W'($urandom_range(13, 32));
      return LEN_W'($urandom_range(33, 63));
   endfunction

   function automatic void queue_load(logic [SYM_W-1:0] s, logic [LEN_W-1:0] l);
      stim_q.push_back(mk_req(CMD_LOAD, s, $urandom, l));
      if (l != 0) loaded_syms.push_back(s);
   endfunction

   // Mostly encodes of loaded symbols, with loads, flushes and noise mixed in.
   function automatic void build_phase(int count, logic [SYM_W-1:0] pad);
      int r;
      repeat ($urandom_range(6, 12)) queue_load(SYM_W'($urandom), rand_length());
      r = $urandom_range(0, 9);
      if (r < 7) queue_load(pad, LEN_W'($urandom_range(1, 8)));
      else if (r < 9) queue_load(pad, '0);
      repeat (count) begin
         r = $urandom_range(0, 99);
         if (r < 6)
            queue_load(SYM_W'($urandom), rand_length());
         else if (r < 14)
            stim_q.push_back(mk_req(CMD_FLUSH, SYM_W'($urandom), $urandom, LEN_W'($urandom)));
         else if (r < 16)
            stim_q.push_back(mk_req(CMD_UNUSED, SYM_W'($urandom), $urandom, LEN_W'($urandom)));
         else if (r < 22 || loaded_syms.size() == 0)
            stim_q.push_back(mk_req(CMD_ENCODE, SYM_W'($urandom), $urandom, LEN_W'($urandom)));
         else
            stim_q.push_back(mk_req(CMD_ENCODE,
                                    SYM_W'(loaded_syms[$urandom_range(0, loaded_syms.size()-1)]),
                                    $urandom, LEN_W'($urandom)));
      end
      stim_q.push_back(mk_req(CMD_FLUSH, SYM_W'($urandom), $urandom, LEN_W'($urandom)));
   endfunction

   // Send every queued item in bursts, noting each one at its acceptance edge.
   task drive_items();
      packer_req_type it;
      int             burst_left;
      burst_left = $urandom_range(1, 12);
      while (stim_q.size() > 0) begin
         it = stim_q.pop_front();
         req_valid <= 1'b1;
         req_command <= it.command;
         req_symbol <= it.symbol;
         req_code_bits <= it.code_bits;
         req_code_length <= it.code_length;
         do @(posedge clock); while (req_stall);
         sb.pack_item(it);
         burst_left--;
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if (sender_gaps) begin
               req_valid <= 1'b0;
               repeat ($urandom_range(1, 5)) @(posedge clock);
            end
         end
      end
      req_valid <= 1'b0;
   endtask

   task csr_write(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   task csr_read(logic [CSR_ADDR_W-1:0] addr, output logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= addr;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      data = prdata;
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   task check_pad_reg(logic [SYM_W-1:0] want);
      logic [CSR_DATA_W-1:0] rd;
      csr_read(REG_PAD_SYMBOL, rd);
      if (rd[SYM_W-1:0] !== want)
         sb.report_mismatch($sformatf("pad_symbol reads %02h, want %02h", rd[SYM_W-1:0], want));
   endtask

   // Wait for every expected word, then idle so the pipe empties.
   task settle();
      while (sb.expected_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      logic [SYM_W-1:0] pad;
      reset = 1'b1;
      req_valid = 1'b0;
      req_command = CMD_LOAD;
      req_symbol = '0;
      req_code_bits = '0;
      req_code_length = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      check_pad_reg(PAD_RESET);

      // unloaded symbol, empty flush, unused command
      stim_q.push_back(mk_req(CMD_ENCODE, 8'd7, 32'h0, 6'd0));
      stim_q.push_back(mk_req(CMD_FLUSH, 8'd0, 32'h0, 6'd0));
      stim_q.push_back(mk_req(CMD_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'd63));
      stim_q.push_back(mk_req(CMD_LOAD, 8'd65, 32'hFFFF_FFFF, 6'd0));
      stim_q.push_back(mk_req(CMD_ENCODE, 8'd65, 32'h0, 6'd0));
      // full-width and overlong codes, high bits above the code ignored
      stim_q.push_back(mk_req(CMD_LOAD, 8'd1, 32'hDEAD_BEEF, 6'd32));
      stim_q.push_back(mk_req(CMD_LOAD, 8'd2, 32'hFFFF_FFFF, 6'd63));
      stim_q.push_back(mk_req(CMD_LOAD, 8'd3, 32'hFFFF_FFF5, 6'd3));
      stim_q.push_back(mk_req(CMD_LOAD, 8'd4, 32'h0, 6'd1));
      stim_q.push_back(mk_req(CMD_LOAD, 8'd5, 32'h0000_0055, 6'd7));
      // 3 pending + 32 bits twice: four words each
      stim_q.push_back(mk_req(CMD_ENCODE, 8'd3, 32'h0, 6'd0));
      stim_q.push_back(mk_req(CMD_ENCODE, 8'd1, 32'h0, 6'd0));
      stim_q.push_back(mk_req(CMD_ENCODE, 8'd2, 32'h0, 6'd0));
      // pad symbol still unloaded: zero pad, then nothing left
      stim_q.push_back(mk_req(CMD_FLUSH, 8'd0, 32'h0, 6'd0));
      stim_q.push_back(mk_req(CMD_FLUSH, 8'd0, 32'h0, 6'd0));
      stim_q.push_back(mk_req(CMD_ENCODE, 8'd5, 32'h0, 6'd0));
      stim_q.push_back(mk_req(CMD_ENCODE, 8'd4, 32'h0, 6'd0));
      // short pad code repeated across the partial word
      stim_q.push_back(mk_req(CMD_LOAD, PAD_RESET, 32'h0000_0004, 6'd3));
      stim_q.push_back(mk_req(CMD_ENCODE, 8'd4, 32'h0, 6'd0));
      stim_q.push_back(mk_req(CMD_FLUSH, 8'd0, 32'h0, 6'd0));
      stim_q.push_back(mk_req(CMD_LOAD, 8'd255, 32'h8000_0001, 6'd33));
      stim_q.push_back(mk_req(CMD_ENCODE, 8'd255, 32'h0, 6'd0));
      stim_q.push_back(mk_req(CMD_ENCODE, 8'd0, 32'h0, 6'd0));
      stim_q.push_back(mk_req(CMD_ENCODE, 8'd3, 32'h0, 6'd0));
      stim_q.push_back(mk_req(CMD_FLUSH, 8'd0, 32'h0, 6'd0));
      loaded_syms = '{1, 2, 3, 4, 5, 32, 255};
      drive_items();
      settle();

      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: pad = 8'd0;
            1: pad = 8'd255;
            4: pad = PAD_RESET;
            default: pad = SYM_W'($urandom);
         endcase
         csr_write(REG_PAD_SYMBOL, CSR_DATA_W'(pad));
         check_pad_reg(pad);
         sb.set_pad(pad);
         sender_gaps = (phase != 0 && phase != 2);
         case (phase)
            0: stall_mode = STALL_NONE;
            2, 3: stall_mode = STALL_HEAVY;
            default: stall_mode = STALL_LIGHT;
         endcase
         build_phase(18, pad);
         drive_items();
         settle();
      end

      if (sb.expected_bytes.size() != 0)
         sb.report_mismatch($sformatf("%0d words never arrived", sb.expected_bytes.size()));
      if (sb.errors == 0)
         $display("huffman_bit_packer verification clean");
      else
         $display("huffman_bit_packer verification failed");
      $finish;
   end

endmodule

// File: huffman_bit_packer.f
sv/hbp_pkg.sv
sv/hbp_table.sv
sv/huffman_bit_packer.sv
tb/sv/huffman_bit_packer_tb.sv
